// ===== rtl/core/sfs_pkg.sv =====
// Shared types and constants for the step frequency servo.
// Used by sfs_mul, sfs_div and step_frequency_servo; depends on nothing.
`default_nettype none
package sfs_pkg;

    localparam int MUL_A_W   = 64;
    localparam int MUL_B_W   = 32;
    localparam int MUL_STEPS = MUL_B_W;
    localparam int MUL_CNT_W = $clog2(MUL_STEPS);
    localparam int DIV_N_W   = 64;
    localparam int DIV_D_W   = 32;
    localparam int DIV_STEPS = DIV_N_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [31:0] ONE_Q16  = 32'h0001_0000;
    localparam logic [17:0] BASE_MIN = 18'd40000;
    localparam logic [17:0] BASE_MAX = 18'd240000;
    localparam logic [15:0] GAIN_ONE = 16'd256;
    localparam logic [62:0] SAT_Q62  = {1'b1, 62'd0};

    localparam logic [2:0] REG_POS_MODE  = 3'd0;
    localparam logic [2:0] REG_STEPS     = 3'd1;
    localparam logic [2:0] REG_BASE_FREQ = 3'd2;
    localparam logic [2:0] REG_MAX_VEL   = 3'd3;
    localparam logic [2:0] REG_MAX_ACC   = 3'd4;
    localparam logic [2:0] REG_RATE      = 3'd5;

    typedef struct packed {
        logic                 start;
        logic [MUL_A_W-1:0]   opa;
        logic [MUL_B_W-1:0]   opb;
    } t_unit_req;

    typedef enum logic [3:0] {
        S_IDLE, S_LIMU, S_ACC, S_ADIV, S_SEL, S_DB, S_DEAD, S_EG,
        S_TR, S_TF, S_VEL, S_VS, S_SLEW1, S_SLEW2, S_SLEW3, S_OUT
    } t_state;

endpackage
`default_nettype wire

// ===== rtl/core/sfs_mul.sv =====
// Bit-serial unsigned shift-add multiplier, one multiplier bit per cycle.
// Depends on sfs_pkg.
`default_nettype none
module sfs_mul (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire sfs_pkg::t_unit_req i_req,
    output logic                    o_done,
    output logic [95:0]             o_prod
);
    import sfs_pkg::*;

    logic [MUL_A_W-1:0]   r_a;
    logic [MUL_A_W-1:0]   r_hi;
    logic [MUL_B_W-1:0]   r_lo;
    logic [MUL_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [MUL_A_W:0]     n_sum;

    always_comb begin
        n_sum = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_a} : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == MUL_CNT_W'(MUL_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a  <= i_req.opa;
            r_hi <= '0;
            r_lo <= i_req.opb;
        end else if (r_busy) begin
            r_hi <= n_sum[MUL_A_W:1];
            r_lo <= {n_sum[0], r_lo[MUL_B_W-1:1]};
        end
    end

    assign o_done = r_done;
    assign o_prod = {r_hi, r_lo};

endmodule
`default_nettype wire

// ===== rtl/core/sfs_div.sv =====
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on sfs_pkg; the divisor must be nonzero.
`default_nettype none
module sfs_div (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire sfs_pkg::t_unit_req i_req,
    output logic                    o_done,
    output logic [63:0]             o_quot
);
    import sfs_pkg::*;

    logic [DIV_N_W-1:0]   r_q;
    logic [DIV_D_W-1:0]   r_rem;
    logic [DIV_D_W-1:0]   r_d;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [DIV_D_W:0]     n_trial;
    logic [DIV_D_W:0]     n_diff;
    logic                 n_ge;

    always_comb begin
        n_trial = {r_rem, r_q[DIV_N_W-1]};
        n_diff  = n_trial - {1'b0, r_d};
        n_ge    = (n_trial >= {1'b0, r_d});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_q   <= i_req.opa;
            r_d   <= i_req.opb;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= n_ge ? n_diff[DIV_D_W-1:0] : n_trial[DIV_D_W-1:0];
            r_q   <= {r_q[DIV_N_W-2:0], n_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule
`default_nettype wire

// ===== rtl/core/step_frequency_servo.sv =====
// Step frequency servo top level: configuration registers, sequencer and datapath.
// Depends on sfs_pkg, sfs_mul and sfs_div.
//
// One request on the slave stream carries one joint's servo inputs for one tick;
// the block answers with exactly one request on the master stream holding the
// new signed step frequency. Configuration registers are written through the
// cfg channel, which is always ready; they must only change while the block is
// idle. Work is sequential: s_axis_tready is high only between items. The work
// of an item is done by the shared bit-serial multiplier (three to six products
// per item) and the radix-2 divider (none to two quotients per item; a zero
// acceleration limit or a given deadband skips one).
// The result sits in an output register, so a stalled receiver does not keep
// the next item from being taken; only a second result waits for the first to
// drain. Reset restores the register defaults (position mode, 1.0 step per
// unit, 200000 steps/s base, no velocity limit, acceleration 1.0, 1000 Hz) and
// clears the frequency and the last target.
`default_nettype none
module step_frequency_servo (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // position_target[31:0], position_actual[63:32], velocity_target[95:64],
    // proportional_gain[111:96], feedforward_gain[127:112],
    // error_deadband[158:128], joint_enable[159]
    input  wire logic [159:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // step_frequency[18:0], zero padding [23:19]
    output logic [23:0]       m_axis_tdata,
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [2:0]   i_cfg_index,
    input  wire logic [31:0]  i_cfg_data
);
    import sfs_pkg::*;

    // configuration
    logic        r_pos_mode;
    logic [31:0] r_spu;
    logic [17:0] r_base;
    logic [30:0] r_maxv;
    logic [30:0] r_maxa;
    logic [16:0] r_rate;

    // latched item
    logic [31:0] r_p, r_f, r_v;
    logic [15:0] r_g, r_ff;
    logic [30:0] r_db;
    logic        r_en;

    // control and datapath state
    t_state      r_state, n_state;
    logic        r_launch;
    logic [49:0] r_limit, n_limit;
    logic [61:0] r_accp, n_accp;
    logic [49:0] r_dv, n_dv;
    logic [32:0] r_dbe, n_dbe;
    logic [33:0] r_e, n_e;
    logic [32:0] r_dp, n_dp;
    logic [33:0] r_emag, n_emag;
    logic        r_eneg, n_eneg;
    logic [32:0] r_dpmag, n_dpmag;
    logic [49:0] r_eg, n_eg;
    logic [49:0] r_t, n_t;
    logic [62:0] r_tf, n_tf;
    logic [63:0] r_velmag, n_velmag;
    logic        r_velneg, n_velneg;
    logic [49:0] r_cmdmag, n_cmdmag;
    logic        r_cmdneg, n_cmdneg;
    logic [51:0] r_cmd, n_cmd;
    logic [51:0] r_hi, n_hi;
    logic [51:0] r_lo, n_lo;
    logic [50:0] r_cur, n_cur;
    logic [31:0] r_last, n_last;
    logic [18:0] r_out, n_out;
    logic        r_ovalid, n_ovalid;

    // derived configuration; the user must keep it stable while an item is in work, the block does not enforce it
    logic [31:0] w_s;
    logic [31:0] w_as;
    logic        w_sneg;
    logic [17:0] w_base;
    logic [16:0] w_rate;

    t_unit_req   w_mreq, w_dreq;
    logic        w_mdone, w_ddone;
    logic [95:0] w_mprod;
    logic [63:0] w_dquot;

    logic        w_in_acc;
    logic [49:0] w_baselim;
    logic [57:0] w_lim40;
    logic [57:0] w_m;
    logic [33:0] w_d1, w_d2, w_dbs;
    logic [51:0] w_cur_x, w_next;
    logic [31:0] w_vmag;

    assign w_s    = (r_spu == '0) ? ONE_Q16 : r_spu;
    assign w_sneg = w_s[31];
    assign w_as   = w_sneg ? (32'd0 - w_s) : w_s;
    assign w_base = (r_base < BASE_MIN) ? BASE_MIN :
                    (r_base > BASE_MAX) ? BASE_MAX : r_base;
    assign w_rate = (r_rate == '0) ? 17'd1 : r_rate;
    assign w_baselim = {w_base, 32'd0};
    assign w_lim40   = {r_limit, 8'd0};
    assign w_cur_x   = {r_cur[50], r_cur};

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {5'd0, r_out};

    sfs_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mreq),
        .o_done  (w_mdone),
        .o_prod  (w_mprod)
    );

    sfs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_dreq),
        .o_done  (w_ddone),
        .o_quot  (w_dquot)
    );

    // Operand selection for the shared units.
    always_comb begin
        w_mreq = '0;
        w_dreq = '0;
        case (r_state)
            S_LIMU: begin
                w_mreq.start = r_launch;
                w_mreq.opa   = {33'd0, r_maxv};
                w_mreq.opb   = w_as;
            end
            S_ACC: begin
                w_mreq.start = r_launch;
                w_mreq.opa   = {33'd0, r_maxa};
                w_mreq.opb   = w_as;
            end
            S_EG: begin
                w_mreq.start = r_launch;
                w_mreq.opa   = {30'd0, r_emag};
                w_mreq.opb   = {16'd0, r_g};
            end
            S_TR: begin
                w_mreq.start = r_launch;
                w_mreq.opa   = {31'd0, r_dpmag};
                w_mreq.opb   = {15'd0, w_rate};
            end
            S_TF: begin
                w_mreq.start = r_launch;
                w_mreq.opa   = {14'd0, r_t};
                w_mreq.opb   = {16'd0, r_ff};
            end
            S_VS: begin
                w_mreq.start = r_launch;
                w_mreq.opa   = r_velmag;
                w_mreq.opb   = w_as;
            end
            S_ADIV: begin
                w_dreq.start = r_launch;
                w_dreq.opa   = {2'd0, r_accp};
                w_dreq.opb   = {15'd0, w_rate};
            end
            S_DB: begin
                w_dreq.start = r_launch;
                w_dreq.opa   = 64'h0000_0001_0000_0000;
                w_dreq.opb   = w_as;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_limit  = r_limit;
        n_accp   = r_accp;
        n_dv     = r_dv;
        n_dbe    = r_dbe;
        n_e      = r_e;
        n_dp     = r_dp;
        n_emag   = r_emag;
        n_eneg   = r_eneg;
        n_dpmag  = r_dpmag;
        n_eg     = r_eg;
        n_t      = r_t;
        n_tf     = r_tf;
        n_velmag = r_velmag;
        n_velneg = r_velneg;
        n_cmdmag = r_cmdmag;
        n_cmdneg = r_cmdneg;
        n_cmd    = r_cmd;
        n_hi     = r_hi;
        n_lo     = r_lo;
        n_cur    = r_cur;
        n_last   = r_last;
        n_out    = r_out;
        n_ovalid = r_ovalid;
        w_dbs    = {1'b0, r_dbe};
        w_d1     = r_e - w_dbs;
        w_d2     = r_e + w_dbs;
        w_m      = (w_mprod > {38'd0, w_lim40}) ? w_lim40 : w_mprod[57:0];
        w_vmag   = r_v[31] ? (32'd0 - r_v) : r_v;
        w_next   = r_cmd;

        if (r_ovalid && m_axis_tready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = S_LIMU;
                end
            end
            S_LIMU: begin
                if (w_mdone) begin
                    if ((r_maxv != '0) && (w_mprod[61:0] < {12'd0, w_baselim})) begin
                        n_limit = w_mprod[49:0];
                    end else begin
                        n_limit = w_baselim;
                    end
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                if (w_mdone) begin
                    n_accp = w_mprod[61:0];
                    if (r_maxa == '0) begin
                        n_dv    = r_limit;
                        n_state = S_SEL;
                    end else begin
                        n_state = S_ADIV;
                    end
                end
            end
            S_ADIV: begin
                if (w_ddone) begin
                    n_dv = (w_dquot < {14'd0, r_limit}) ? w_dquot[49:0] : r_limit;
                    n_state = S_SEL;
                end
            end
            S_SEL: begin
                if (r_pos_mode) begin
                    n_e    = {{2{r_p[31]}}, r_p} - {{2{r_f[31]}}, r_f};
                    n_dp   = {r_p[31], r_p} - {r_last[31], r_last};
                    n_last = r_p;
                    if (r_db == '0) begin
                        n_state = S_DB;
                    end else begin
                        n_dbe   = {2'd0, r_db};
                        n_state = S_DEAD;
                    end
                end else begin
                    n_velmag = {24'd0, w_vmag, 8'd0};
                    n_velneg = r_v[31];
                    n_state  = S_VS;
                end
            end
            S_DB: begin
                if (w_ddone) begin
                    n_dbe   = w_dquot[32:0];
                    n_state = S_DEAD;
                end
            end
            S_DEAD: begin
                // Errors inside the deadband count as zero; outside it they shrink by it.
                if (!w_d1[33] && (w_d1 != '0)) begin
                    n_emag = w_d1;
                    n_eneg = 1'b0;
                end else if (w_d2[33]) begin
                    n_emag = 34'd0 - w_d2;
                    n_eneg = 1'b1;
                end else begin
                    n_emag = '0;
                    n_eneg = 1'b0;
                end
                n_dpmag = r_dp[32] ? (33'd0 - r_dp) : r_dp;
                n_state = S_EG;
            end
            S_EG: begin
                if (w_mdone) begin
                    n_eg    = w_mprod[49:0];
                    n_state = S_TR;
                end
            end
            S_TR: begin
                if (w_mdone) begin
                    n_t     = w_mprod[49:0];
                    n_state = S_TF;
                end
            end
            S_TF: begin
                if (w_mdone) begin
                    n_tf    = (w_mprod[95:62] != '0) ? SAT_Q62 : w_mprod[62:0];
                    n_state = S_VEL;
                end
            end
            S_VEL: begin
                // Sign-magnitude sum of the proportional and feedforward terms.
                if (r_eneg == r_dp[32]) begin
                    n_velmag = {14'd0, r_eg} + {1'b0, r_tf};
                    n_velneg = r_eneg;
                end else if ({13'd0, r_eg} <= r_tf) begin
                    n_velmag = {1'b0, r_tf - {13'd0, r_eg}};
                    n_velneg = r_dp[32];
                end else begin
                    n_velmag = {14'd0, r_eg - r_tf[49:0]};
                    n_velneg = r_eneg;
                end
                n_state = S_VS;
            end
            S_VS: begin
                if (w_mdone) begin
                    n_cmdmag = w_m[57:8];
                    n_cmdneg = r_velneg ^ w_sneg;
                    n_state  = S_SLEW1;
                end
            end
            S_SLEW1: begin
                n_cmd   = r_cmdneg ? (52'd0 - {2'd0, r_cmdmag}) : {2'd0, r_cmdmag};
                n_hi    = w_cur_x + {2'd0, r_dv};
                n_state = S_SLEW2;
            end
            S_SLEW2: begin
                n_lo    = w_cur_x - {2'd0, r_dv};
                n_state = S_SLEW3;
            end
            S_SLEW3: begin
                if ($signed(r_cmd) > $signed(r_hi)) begin
                    w_next = r_hi;
                end else if ($signed(r_cmd) < $signed(r_lo)) begin
                    w_next = r_lo;
                end else begin
                    w_next = r_cmd;
                end
                if (!r_en) begin
                    w_next = '0;
                end
                n_cur   = w_next[50:0];
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_ovalid || m_axis_tready) begin
                    // Integer part truncated toward zero.
                    n_out = r_cur[50:32] +
                            19'((r_cur[50] && (r_cur[31:0] != '0)) ? 1 : 0);
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_launch   <= 1'b0;
            r_ovalid   <= 1'b0;
            r_cur      <= '0;
            r_last     <= '0;
            r_pos_mode <= 1'b1;
            r_spu      <= ONE_Q16;
            r_base     <= 18'd200000;
            r_maxv     <= '0;
            r_maxa     <= 31'(ONE_Q16);
            r_rate     <= 17'd1000;
        end else begin
            r_state  <= n_state;
            r_launch <= (n_state != r_state);
            r_ovalid <= n_ovalid;
            r_cur    <= n_cur;
            r_last   <= n_last;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_POS_MODE:  r_pos_mode <= i_cfg_data[0];
                    REG_STEPS:     r_spu      <= i_cfg_data;
                    REG_BASE_FREQ: r_base     <= i_cfg_data[17:0];
                    REG_MAX_VEL:   r_maxv     <= i_cfg_data[30:0];
                    REG_MAX_ACC:   r_maxa     <= i_cfg_data[30:0];
                    REG_RATE:      r_rate     <= i_cfg_data[16:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_p  <= s_axis_tdata[31:0];
            r_f  <= s_axis_tdata[63:32];
            r_v  <= s_axis_tdata[95:64];
            r_g  <= (s_axis_tdata[111:96] == '0) ? GAIN_ONE : s_axis_tdata[111:96];
            r_ff <= (s_axis_tdata[127:112] == '0) ? GAIN_ONE : s_axis_tdata[127:112];
            r_db <= s_axis_tdata[158:128];
            r_en <= s_axis_tdata[159];
        end
        r_limit  <= n_limit;
        r_accp   <= n_accp;
        r_dv     <= n_dv;
        r_dbe    <= n_dbe;
        r_e      <= n_e;
        r_dp     <= n_dp;
        r_emag   <= n_emag;
        r_eneg   <= n_eneg;
        r_dpmag  <= n_dpmag;
        r_eg     <= n_eg;
        r_t      <= n_t;
        r_tf     <= n_tf;
        r_velmag <= n_velmag;
        r_velneg <= n_velneg;
        r_cmdmag <= n_cmdmag;
        r_cmdneg <= n_cmdneg;
        r_cmd    <= n_cmd;
        r_hi     <= n_hi;
        r_lo     <= n_lo;
        r_out    <= n_out;
    end

endmodule
`default_nettype wire
